FILE: sv/uf_pkg.sv
// shared constants for the quick-find disjoint-set table
`timescale 1ns / 1ps

package uf_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic MODE_JOIN  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

FILE: sv/uf_cell.sv
// one cell of the label ring: holds a single component label
`timescale 1ns / 1ps

module uf_cell #(
  parameter int LABEL_W = 10,
  parameter logic [LABEL_W-1:0] RESET_LABEL = '0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LABEL_W-1:0] label_in,
  output logic [LABEL_W-1:0] label
);

  always_ff @(posedge clk) begin
    if (rst) begin
      label <= RESET_LABEL;
    end else begin
      label <= label_in;
    end
  end

endmodule

FILE: sv/union_find_quick_find.sv
// top level of the quick-find disjoint-set table built on a rotating label ring
`timescale 1ns / 1ps

// quick-find disjoint-set table
// request channel: start is sampled at a rising edge; a request is taken when
//   start is high and busy is low. mode selects join or query, first_element and
//   second_element name the two elements.
// result channel: done pulses for one cycle with connected and index_error; the
//   receiver cannot stall, so the result is only valid during that cycle.
// config: cfg_write loads cfg_data into element_count; write only while idle.
// the labels live in a ring of MAX_ELEMENTS cells that shifts by one every
//   cycle; the head cell (cell 0) carries the entry whose index is head_idx.
// an out-of-range index shows its result in the cycle right after the
//   request. otherwise the block waits in S_SEEK for both elements to pass
//   the head; a query, or a join of connected elements, then reports in the
//   next cycle. a real join adds one full ring turn in S_WALK that relabels
//   every entry as it passes the head, and then reports.
// flow: one request in flight at a time; busy drops in the cycle after done,
//   so the next request can be taken in the cycle after the result.
// reset: synchronous; every cell gets its own index as label, element_count
//   returns to 1024, the block goes idle. no clearing pass is needed.
module union_find_quick_find
  import uf_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [INDEX_W-1:0] first_element,
  input  logic [INDEX_W-1:0] second_element,
  output logic               done,
  output logic               connected,
  output logic               index_error,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int LW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  // common width for comparing ring indexes with request indexes
  localparam int CW = (LW > INDEX_W) ? LW : INDEX_W;
  // width that holds both the element count and the table size
  localparam int SW = ($clog2(MAX_ELEMENTS + 1) > COUNT_W) ?
                      $clog2(MAX_ELEMENTS + 1) : COUNT_W;
  localparam logic [LW-1:0] LAST_IDX = LW'(MAX_ELEMENTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEEK = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]         state;
  logic [COUNT_W-1:0] element_count;
  logic [LW-1:0]      head_idx;
  logic [LW-1:0]      walk_cnt;
  logic               mode_q;
  logic [INDEX_W-1:0] a_q;
  logic [INDEX_W-1:0] b_q;
  logic [LW-1:0]      la;
  logic [LW-1:0]      lb;
  logic               got_a;
  logic               got_b;

  logic [LW-1:0] ring [MAX_ELEMENTS];
  logic [LW-1:0] tail_in;
  logic [LW-1:0] head_label;

  logic          accept;
  logic [SW-1:0] eff_count;
  logic          range_err;
  logic          hit_a;
  logic          hit_b;
  logic          got_a_now;
  logic          got_b_now;
  logic [LW-1:0] la_now;
  logic [LW-1:0] lb_now;

  // label ring: each cell takes its right neighbor, the last cell takes the head
  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    if (k == MAX_ELEMENTS - 1) begin : g_tail
      uf_cell #(
        .LABEL_W    (LW),
        .RESET_LABEL(LW'(k))
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .label_in(tail_in),
        .label   (ring[k])
      );
    end else begin : g_body
      uf_cell #(
        .LABEL_W    (LW),
        .RESET_LABEL(LW'(k))
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .label_in(ring[k+1]),
        .label   (ring[k])
      );
    end
  end

  assign head_label = ring[0];

  // relabel members of the second component as they leave the head
  assign tail_in = (state == S_WALK && head_label == lb) ? la : head_label;

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_RESP);
  assign accept = start && !busy;

  // effective count is the smaller of the register and the table size
  always_comb begin
    eff_count = (SW'(element_count) < SW'(MAX_ELEMENTS)) ?
                SW'(element_count) : SW'(MAX_ELEMENTS);
    range_err = (SW'(first_element) >= eff_count) ||
                (SW'(second_element) >= eff_count);
  end

  // capture labels as the requested elements pass the head
  always_comb begin
    hit_a     = (CW'(head_idx) == CW'(a_q));
    hit_b     = (CW'(head_idx) == CW'(b_q));
    got_a_now = got_a || hit_a;
    got_b_now = got_b || hit_b;
    la_now    = got_a ? la : head_label;
    lb_now    = got_b ? lb : head_label;
  end

  // ring position counter, runs every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
    end else if (head_idx == LAST_IDX) begin
      head_idx <= '0;
    end else begin
      head_idx <= head_idx + 1'b1;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
    end else if (cfg_write) begin
      element_count <= cfg_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      got_a <= 1'b0;
      got_b <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q <= mode;
            a_q    <= first_element;
            b_q    <= second_element;
            got_a  <= 1'b0;
            got_b  <= 1'b0;
            if (range_err) begin
              connected   <= 1'b0;
              index_error <= 1'b1;
              state       <= S_RESP;
            end else begin
              index_error <= 1'b0;
              state       <= S_SEEK;
            end
          end
        end
        S_SEEK: begin
          la    <= la_now;
          lb    <= lb_now;
          got_a <= got_a_now;
          got_b <= got_b_now;
          if (got_a_now && got_b_now) begin
            connected <= (la_now == lb_now);
            walk_cnt  <= '0;
            if (mode_q == MODE_QUERY || la_now == lb_now) begin
              state <= S_RESP;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // one full turn visits every entry once at the head
          if (walk_cnt == LAST_IDX) begin
            state <= S_RESP;
          end else begin
            walk_cnt <= walk_cnt + 1'b1;
          end
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/uf_checker.sv
// port-level checks for the quick-find table, bound to the top level
`timescale 1ns / 1ps

module uf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic connected,
  input logic index_error
);

  // a taken request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst || $past(rst))
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // the result strobe never stays high back to back
  a_single_result: assert property (@(posedge clk) disable iff (rst || $past(rst))
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a result only belongs to a request in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst || $past(rst))
    done |-> busy)
    else $error("result without a request in flight");

  // an index error never reports a connection
  a_err_not_conn: assert property (@(posedge clk) disable iff (rst || $past(rst))
    done && index_error |-> !connected)
    else $error("index error with connected set");

  // busy only drops after the result has been shown
  a_busy_drop: assert property (@(posedge clk) disable iff (rst || $past(rst))
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

endmodule

bind union_find_quick_find uf_checker u_uf_checker (.*);
